// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks with reset qualification; compiled out when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// File: design/ddc_pkg.sv
// ----------------------------------------------------------------------------
// ddc_pkg
// Shared types, constants and helper functions of the differential drive
// controller.
// ----------------------------------------------------------------------------
`default_nettype none

package ddc_pkg;

    localparam int COUNT_W = 32;
    localparam int POS_W   = 31;
    localparam int GAIN_W  = 16;
    localparam int PROD_W  = POS_W + GAIN_W;      // 47
    localparam int MAG_W   = PROD_W - 8;          // Q8.8 product, integer part
    localparam int CFG_W   = 31;
    localparam int IN_W    = 64;
    localparam int OUT_W   = 72;

    localparam logic [POS_W-1:0] STOP_TOLERANCE = 31'd3;
    localparam logic [6:0]       MAX_BASE_SPEED = 7'd90;
    localparam logic [POS_W-1:0] MAX31          = 31'h7FFF_FFFF;

    typedef enum logic [1:0] {
        MODE_FWD        = 2'd0,
        MODE_REV        = 2'd1,
        MODE_TURN_LEFT  = 2'd2,
        MODE_TURN_RIGHT = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_MODE       = 3'd0,
        REG_BASE_SPEED = 3'd1,
        REG_SYNC_GAIN  = 3'd2,
        REG_TURN_GAIN  = 3'd3,
        REG_GOAL_TICKS = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] rr;
        logic [7:0] rf;
        logic [7:0] lr;
        logic [7:0] lf;
    } duty_set_t;

    // clamp a wide speed to 0..100; anything at or above 100 maps to full duty
    function automatic logic [6:0] sat_speed(input logic [MAG_W:0] x);
        if (x >= (MAG_W+1)'(100))
            return 7'd100;
        else
            return x[6:0];
    endfunction

    // 0 -> 0, >=100 -> 255, else 35 + s*220/100; /5 done as *13108 >> 16
    function automatic logic [7:0] speed_to_duty(input logic [6:0] s);
        logic [10:0] x;
        logic [24:0] q;
        x = 11'(s) * 11'd11;
        q = 25'(x) * 25'd13108;
        if (s == 7'd0)
            return 8'd0;
        else if (s >= 7'd100)
            return 8'd255;
        else
            return 8'd35 + q[23:16];
    endfunction

endpackage

`default_nettype wire

// File: design/differential_drive_controller.sv
// ----------------------------------------------------------------------------
// differential_drive_controller
// Proportional wheel synchronization for a two-wheel drive: encoder counts in,
// four PWM duties plus status out, one result transaction per input.
// ----------------------------------------------------------------------------
// Usage:
//  - s_tdata carries one control tick: left count [31:0], right count [63:32],
//    both raw signed encoder counts. One result transaction comes out on m_*
//    for every input transaction, in order.
//  - Registers (mode, base_speed, sync_gain, turn_gain, goal_ticks) are
//    written through cfg_we/cfg_addr/cfg_data; the user must write them only
//    while idle, as the block does not enforce it; an unknown index is ignored.
//  - Each tick runs through a small sequencer that reuses one 31x16
//    multiplier and one absolute-difference unit. It steps through AVG,
//    DIST, MUL1, MUL2 and DUTY in straight modes, with TURN2 added in turn
//    modes (the turn modes need a second pass through the multiplier).
//    s_tready is high only while the sequencer is idle, so a new tick is
//    not accepted before the last one has been through.
//  - The result sits in an output register; if an earlier result is still
//    held and m_tready is low the sequencer waits in its last step and the
//    held duties are not touched until the result can be loaded.
//  - Reset clears the held duties and last counts, and loads the register
//    defaults: forward, base speed 30, both gains 1.0, goal 0.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module differential_drive_controller (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // config write port
    input  wire logic                         cfg_we,
    input  wire logic [2:0]                   cfg_addr,
    input  wire logic [ddc_pkg::CFG_W-1:0]    cfg_data,
    // input stream
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // [31:0] left_count, [63:32] right_count
    input  wire logic [ddc_pkg::IN_W-1:0]     s_tdata,
    // output stream
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // [7:0] left_fwd_duty, [15:8] left_rev_duty, [23:16] right_fwd_duty,
    // [31:24] right_rev_duty, [32] updated, [33] done_res,
    // [64:34] average_position, [71:65] zero
    output logic [ddc_pkg::OUT_W-1:0]         m_tdata
);

    localparam int POS_W  = ddc_pkg::POS_W;
    localparam int PROD_W = ddc_pkg::PROD_W;
    localparam int MAG_W  = ddc_pkg::MAG_W;

    // one-hot sequencer
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,  // wait for a tick
        ST_AVG   = 7'b0000010,  // average, change detect
        ST_DIST  = 7'b0000100,  // first absdiff
        ST_MUL1  = 7'b0001000,  // first product, second absdiff, done
        ST_MUL2  = 7'b0010000,  // first speed(s), second product (turns)
        ST_TURN2 = 7'b0100000,  // right wheel speed in turns
        ST_DUTY  = 7'b1000000   // duty mapping, held update, output load
    } state_t;

    state_t state_reg, state_next;

    // config registers
    ddc_pkg::mode_t             mode_reg;
    logic [6:0]                 base_speed_reg;
    logic [ddc_pkg::GAIN_W-1:0] sync_gain_reg;
    logic [ddc_pkg::GAIN_W-1:0] turn_gain_reg;
    logic [POS_W-1:0]           goal_reg;

    // control/state registers
    logic                       out_valid_reg, out_valid_next;
    logic [POS_W-1:0]           last_left_reg, last_left_next;
    logic [POS_W-1:0]           last_right_reg, last_right_next;
    ddc_pkg::duty_set_t         held_reg, held_next;

    // working registers (no reset)
    logic [POS_W-1:0]           l_reg, l_next;
    logic [POS_W-1:0]           r_reg, r_next;
    logic [POS_W-1:0]           avg_reg, avg_next;
    logic                       changed_reg, changed_next;
    logic [POS_W-1:0]           a_reg, a_next;          // multiplier operand
    logic                       pos_a_reg, pos_a_next;  // r>l (straight) / goal>l (turn)
    logic                       pos_b_reg, pos_b_next;  // goal>r
    logic                       near_reg, near_next;
    logic                       done_reg, done_next;
    logic [PROD_W-1:0]          prod_reg, prod_next;
    logic [6:0]                 spd_l_reg, spd_l_next;
    logic [6:0]                 spd_r_reg, spd_r_next;
    logic [ddc_pkg::OUT_W-1:0]  out_data_reg, out_data_next;

    // shared units
    logic [POS_W-1:0]           ad_x, ad_y, ad_mag;
    logic                       ad_gt;
    logic [ddc_pkg::GAIN_W-1:0] mul_gain;
    logic [PROD_W-1:0]          mul_out;

    // misc comb
    logic                       is_turn;
    logic [ddc_pkg::COUNT_W-1:0] neg_left, neg_right;
    logic [ddc_pkg::COUNT_W-1:0] pos_sum;
    logic [MAG_W-1:0]           prod_mag;
    logic [6:0]                 base_clamped;
    logic [MAG_W:0]             straight_sum;
    logic                       fwd_l, fwd_r;
    logic [7:0]                 duty_l, duty_r;
    logic                       out_free;

    assign is_turn  = (mode_reg == ddc_pkg::MODE_TURN_LEFT) ||
                      (mode_reg == ddc_pkg::MODE_TURN_RIGHT);
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign out_free = !out_valid_reg || m_tready;

    // absdiff operand select: first pass l against r (straight) or goal,
    // second pass goal against r
    always_comb
    begin
        if (state_reg == ST_DIST) begin
            ad_x = is_turn ? goal_reg : r_reg;
            ad_y = l_reg;
        end else begin
            ad_x = goal_reg;
            ad_y = r_reg;
        end
    end

    ddc_absdiff u_absdiff (
        .x   (ad_x),
        .y   (ad_y),
        .mag (ad_mag),
        .gt  (ad_gt)
    );

    // the one multiplier
    assign mul_gain = (state_reg == ST_MUL1 && !is_turn) ? sync_gain_reg : turn_gain_reg;
    assign mul_out  = {{(PROD_W-POS_W){1'b0}}, a_reg} *
                      {{(PROD_W-ddc_pkg::GAIN_W){1'b0}}, mul_gain};

    assign prod_mag     = prod_reg[PROD_W-1:8];   // Q8.8 -> integer, toward zero
    assign base_clamped = (base_speed_reg > ddc_pkg::MAX_BASE_SPEED) ?
                          ddc_pkg::MAX_BASE_SPEED : base_speed_reg;
    assign straight_sum = {{(MAG_W+1-7){1'b0}}, base_clamped} + {1'b0, prod_mag};

    // absolute counts; the most negative count saturates
    assign neg_left  = -s_tdata[31:0];
    assign neg_right = -s_tdata[63:32];
    assign pos_sum   = {1'b0, l_reg} + {1'b0, r_reg};

    // wheel directions
    always_comb
    begin
        case (mode_reg)
            ddc_pkg::MODE_FWD:
            begin
                fwd_l = 1'b1;
                fwd_r = 1'b1;
            end
            ddc_pkg::MODE_REV:
            begin
                fwd_l = 1'b0;
                fwd_r = 1'b0;
            end
            ddc_pkg::MODE_TURN_LEFT:
            begin
                fwd_l = !pos_a_reg;
                fwd_r = pos_b_reg;
            end
            ddc_pkg::MODE_TURN_RIGHT:
            begin
                fwd_l = pos_a_reg;
                fwd_r = !pos_b_reg;
            end
            default:
            begin
                fwd_l = 1'b1;
                fwd_r = 1'b1;
            end
        endcase
    end

    assign duty_l = ddc_pkg::speed_to_duty(spd_l_reg);
    assign duty_r = ddc_pkg::speed_to_duty(spd_r_reg);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        last_left_next  = last_left_reg;
        last_right_next = last_right_reg;
        held_next       = held_reg;
        l_next          = l_reg;
        r_next          = r_reg;
        avg_next        = avg_reg;
        changed_next    = changed_reg;
        a_next          = a_reg;
        pos_a_next      = pos_a_reg;
        pos_b_next      = pos_b_reg;
        near_next       = near_reg;
        done_next       = done_reg;
        prod_next       = prod_reg;
        spd_l_next      = spd_l_reg;
        spd_r_next      = spd_r_reg;
        out_data_next   = out_data_reg;

        if (m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid) begin
                    l_next = s_tdata[31] ?
                             (neg_left[31] ? ddc_pkg::MAX31 : neg_left[POS_W-1:0]) :
                             s_tdata[POS_W-1:0];
                    r_next = s_tdata[63] ?
                             (neg_right[31] ? ddc_pkg::MAX31 : neg_right[POS_W-1:0]) :
                             s_tdata[32 +: POS_W];
                    state_next = ST_AVG;
                end
            end
            ST_AVG:
            begin
                avg_next     = pos_sum[POS_W:1];
                changed_next = (l_reg != last_left_reg) || (r_reg != last_right_reg);
                last_left_next  = l_reg;
                last_right_next = r_reg;
                state_next   = ST_DIST;
            end
            ST_DIST:
            begin
                a_next     = ad_mag;
                pos_a_next = ad_gt;
                near_next  = (ad_mag <= ddc_pkg::STOP_TOLERANCE);
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                prod_next  = mul_out;
                a_next     = ad_mag;    // |goal - r| for the right wheel
                pos_b_next = ad_gt;
                done_next  = is_turn ? (near_reg || (ad_mag <= ddc_pkg::STOP_TOLERANCE)) :
                                       (avg_reg >= goal_reg);
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                if (is_turn) begin
                    spd_l_next = ddc_pkg::sat_speed({1'b0, prod_mag});
                    prod_next  = mul_out;
                    state_next = ST_TURN2;
                end else begin
                    // correction goes to the lagging wheel
                    if (pos_a_reg) begin
                        spd_l_next = ddc_pkg::sat_speed(straight_sum);
                        spd_r_next = base_clamped;
                    end else begin
                        spd_l_next = base_clamped;
                        spd_r_next = ddc_pkg::sat_speed(straight_sum);
                    end
                    state_next = ST_DUTY;
                end
            end
            ST_TURN2:
            begin
                spd_r_next = ddc_pkg::sat_speed({1'b0, prod_mag});
                state_next = ST_DUTY;
            end
            ST_DUTY:
            begin
                if (out_free) begin
                    if (changed_reg) begin
                        held_next.lf = fwd_l ? duty_l : 8'd0;
                        held_next.lr = fwd_l ? 8'd0 : duty_l;
                        held_next.rf = fwd_r ? duty_r : 8'd0;
                        held_next.rr = fwd_r ? 8'd0 : duty_r;
                    end
                    if (done_reg)
                        held_next = '0;
                    out_data_next  = {7'd0, avg_reg, done_reg, changed_reg,
                                      held_next.rr, held_next.rf,
                                      held_next.lr, held_next.lf};
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            last_left_reg  <= '0;
            last_right_reg <= '0;
            held_reg       <= '0;
            mode_reg       <= ddc_pkg::MODE_FWD;
            base_speed_reg <= 7'd30;
            sync_gain_reg  <= 16'd256;
            turn_gain_reg  <= 16'd256;
            goal_reg       <= '0;
        end else begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            last_left_reg  <= last_left_next;
            last_right_reg <= last_right_next;
            held_reg       <= held_next;
            if (cfg_we) begin
                case (cfg_addr)
                    ddc_pkg::REG_MODE:       mode_reg       <= ddc_pkg::mode_t'(cfg_data[1:0]);
                    ddc_pkg::REG_BASE_SPEED: base_speed_reg <= cfg_data[6:0];
                    ddc_pkg::REG_SYNC_GAIN:  sync_gain_reg  <= cfg_data[15:0];
                    ddc_pkg::REG_TURN_GAIN:  turn_gain_reg  <= cfg_data[15:0];
                    ddc_pkg::REG_GOAL_TICKS: goal_reg       <= cfg_data;
                    default:                 ;
                endcase
            end
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        l_reg        <= l_next;
        r_reg        <= r_next;
        avg_reg      <= avg_next;
        changed_reg  <= changed_next;
        a_reg        <= a_next;
        pos_a_reg    <= pos_a_next;
        pos_b_reg    <= pos_b_next;
        near_reg     <= near_next;
        done_reg     <= done_next;
        prod_reg     <= prod_next;
        spd_l_reg    <= spd_l_next;
        spd_r_reg    <= spd_r_next;
        out_data_reg <= out_data_next;
    end

    // checks
    `ASSERT_CLK(a_done_zero_duty, clk, rst_n,
        (m_tvalid && m_tdata[33]) |-> (m_tdata[31:0] == 32'd0),
        "done result carries nonzero duty")
    `ASSERT_NEVER(a_wheel_both_dirs, clk, rst_n,
        m_tvalid && (((m_tdata[7:0] != 8'd0) && (m_tdata[15:8] != 8'd0)) ||
                     ((m_tdata[23:16] != 8'd0) && (m_tdata[31:24] != 8'd0))),
        "wheel driven forward and reverse at once")
    `ASSERT_CLK(a_held_only_in_duty, clk, rst_n,
        (state_reg != ST_DUTY) |=> $stable(held_reg),
        "held duties changed outside duty step")
    `ASSERT_CLK(a_result_from_duty, clk, rst_n,
        $rose(out_valid_reg) |-> $past(state_reg == ST_DUTY),
        "result raised without a finished tick")
    `ASSERT_CLK(a_busy_after_accept, clk, rst_n,
        (s_tvalid && s_tready) |=> (!s_tready && (state_reg == ST_AVG)),
        "sequencer did not start on accepted tick")

endmodule

`default_nettype wire

// File: design/ddc_absdiff.sv
// ----------------------------------------------------------------------------
// ddc_absdiff
// Shared absolute-difference unit: |x - y| and x > y for 31-bit positions.
// ----------------------------------------------------------------------------
`default_nettype none

module ddc_absdiff (
    input  wire logic [ddc_pkg::POS_W-1:0] x,
    input  wire logic [ddc_pkg::POS_W-1:0] y,
    output logic      [ddc_pkg::POS_W-1:0] mag,
    output logic                           gt
);

    logic [ddc_pkg::POS_W:0] d;
    logic [ddc_pkg::POS_W:0] d_neg;

    always_comb
    begin
        d     = {1'b0, x} - {1'b0, y};
        d_neg = -d;
        gt    = !d[ddc_pkg::POS_W] && (d != '0);
        mag   = d[ddc_pkg::POS_W] ? d_neg[ddc_pkg::POS_W-1:0] : d[ddc_pkg::POS_W-1:0];
    end

endmodule

`default_nettype wire
